FILE: hdl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types, constants and the coefficient table for the gas sensor ppm filter.
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int SAMPLE_BITS      = 12;
    localparam int OVERSAMPLE_COUNT = 32;
    localparam int OVS_SHIFT        = $clog2(OVERSAMPLE_COUNT);
    localparam int COUNT_BITS       = OVS_SHIFT;
    localparam int SUM_BITS         = SAMPLE_BITS + OVS_SHIFT;
    localparam int QUEUE_DEPTH      = 4;

    localparam int WEIGHT_BITS = 17;
    localparam int RES_BITS    = 16;
    localparam int LOG_BITS    = 23;
    localparam int EP_BITS     = 41;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 17'd65536;
    localparam logic [EP_BITS-1:0]     LOG2_GAIN_Q32 = 41'd433812 << 16;
    localparam logic [17:0]            SLOPE_Q16  = 18'd95551;
    localparam logic [31:0]            Q16_MAX    = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] REG_SMOOTHING_WEIGHT     = 2'd0;
    localparam logic [1:0] REG_LOAD_RESISTANCE      = 2'd1;
    localparam logic [1:0] REG_CLEAN_AIR_RESISTANCE = 2'd2;

    localparam logic [WEIGHT_BITS-1:0] RST_SMOOTHING_WEIGHT     = 17'd6554;
    localparam logic [RES_BITS-1:0]    RST_LOAD_RESISTANCE      = 16'd2560;
    localparam logic [RES_BITS-1:0]    RST_CLEAN_AIR_RESISTANCE = 16'd3840;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] smoothing_weight;
        logic [RES_BITS-1:0]    load_resistance;
        logic [RES_BITS-1:0]    clean_air_resistance;
    } gsp_cfg_t;

    // c_k = floor(sqrt(c_(k-1) * 2^30)), c_0 = 2.0 in Q1.30; entry k-1 holds c_k
    function automatic logic [511:0] exp_coef_table();
        logic [511:0] tbl;
        logic [63:0]  c;
        logic [63:0]  v;
        logic [63:0]  res;
        logic [63:0]  bit_w;
        tbl = '0;
        c   = 64'd1 << 31;
        for (int k = 0; k < 16; k++) begin
            v     = c << 30;
            res   = '0;
            bit_w = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (v >= res + bit_w) begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            c = res;
            tbl[k*32 +: 32] = c[31:0];
        end
        return tbl;
    endfunction

endpackage

FILE: hdl/gas_sensor_ppm_ema_filter.sv
// Sequence: after the last sample of a block its mean passes the queue, then start,
//   log2 of four operands (init plus squaring steps each), exp2 setup and steps,
//   scale, EMA (first step only for the first block) and output; a zero or full-scale mean skips log2 and exp2.
// Throughput: one sample per cycle while the 4-block queue has room; the shared
//   squaring/multiply sequencer takes a new block only once the last one is output.
// Reset (aresetn, sync, active low): clears FSM, counters, pointers and smoothed value, restores register defaults.
// ----------------------------------------------------------------------------
// gas_sensor_ppm_ema_filter
// Oversampled gas sensor to ppm converter with exponential smoothing.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_ema_filter #(
    parameter int QUEUE_DEPTH = gsp_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_sample
    input  logic        s_tuser,   // [0] sample_ok
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] ppm_value, [27:16] average_sample
    output logic        m_tuser,   // [0] saturated
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata
);

    logic [16:0]       weight_reg;
    logic [15:0]       load_reg;
    logic [15:0]       clean_reg;
    gsp_pkg::gsp_cfg_t cfg;

    logic              f_valid, f_ready;
    gsp_pkg::sample_t  f_avg;
    logic              q_valid, q_ready;
    gsp_pkg::sample_t  q_avg;
    logic [15:0]       ppm;
    gsp_pkg::sample_t  avg_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= gsp_pkg::RST_SMOOTHING_WEIGHT;
            load_reg   <= gsp_pkg::RST_LOAD_RESISTANCE;
            clean_reg  <= gsp_pkg::RST_CLEAN_AIR_RESISTANCE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gsp_pkg::REG_SMOOTHING_WEIGHT:     weight_reg <= cfg_wdata;
                gsp_pkg::REG_LOAD_RESISTANCE:      load_reg   <= cfg_wdata[15:0];
                gsp_pkg::REG_CLEAN_AIR_RESISTANCE: clean_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign cfg.smoothing_weight     = weight_reg;
    assign cfg.load_resistance      = load_reg;
    assign cfg.clean_air_resistance = clean_reg;

    gsp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_sample  (s_tdata[gsp_pkg::SAMPLE_BITS-1:0]),
        .s_ok      (s_tuser),
        .blk_valid (f_valid),
        .blk_ready (f_ready),
        .blk_avg   (f_avg)
    );

    gsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_avg),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_avg)
    );

    gsp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .blk_valid (q_valid),
        .blk_ready (q_ready),
        .blk_avg   (q_avg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ppm   (ppm),
        .out_avg   (avg_out),
        .out_sat   (m_tuser)
    );

    assign m_tdata = {4'b0000, avg_out, ppm};

endmodule

FILE: hdl/gsp_front.sv
// ----------------------------------------------------------------------------
// gsp_front
// Sample accumulator: sums a block of samples and emits the truncated mean.
// ----------------------------------------------------------------------------
module gsp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gsp_pkg::sample_t     s_sample,
    input  logic                 s_ok,
    output logic                 blk_valid,
    input  logic                 blk_ready,
    output gsp_pkg::sample_t     blk_avg
);

    logic [gsp_pkg::SUM_BITS-1:0]   sum_reg, sum_next;
    logic [gsp_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [gsp_pkg::SUM_BITS-1:0]   sum_add;
    logic                           accept;
    logic                           last;

    // queue full stalls the whole input, simple and enough at sensor rates
    assign s_ready = blk_ready;
    assign accept  = s_valid && s_ready;
    assign last    = (count_reg == gsp_pkg::COUNT_BITS'(gsp_pkg::OVERSAMPLE_COUNT - 1));
    assign sum_add = sum_reg + (s_ok ? gsp_pkg::SUM_BITS'(s_sample) : '0);

    assign blk_valid = accept && last;
    assign blk_avg   = sum_add[gsp_pkg::SUM_BITS-1:gsp_pkg::OVS_SHIFT];

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept) begin
            if (last) begin
                sum_next   = '0;
                count_next = '0;
            end else begin
                sum_next   = sum_add;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/gsp_queue.sv
// ----------------------------------------------------------------------------
// gsp_queue
// Short queue of block averages between the accumulator and the math engine.
// ----------------------------------------------------------------------------
module gsp_queue #(
    parameter int DEPTH = gsp_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  gsp_pkg::sample_t wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output gsp_pkg::sample_t rd_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    gsp_pkg::sample_t    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] fill_reg, fill_next;
    logic                push, pop;

    assign wr_ready = (fill_reg != CNT_BITS'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: hdl/gsp_back.sv
// ----------------------------------------------------------------------------
// gsp_back
// Math engine: log2 ratio, exp2 power law, EMA and the output register.
// ----------------------------------------------------------------------------
module gsp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  gsp_pkg::gsp_cfg_t cfg,
    input  logic              blk_valid,
    output logic              blk_ready,
    input  gsp_pkg::sample_t  blk_avg,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       out_ppm,
    output gsp_pkg::sample_t  out_avg,
    output logic              out_sat
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_START     = 4'd1;
    localparam logic [3:0] ST_LOG_INIT  = 4'd2;
    localparam logic [3:0] ST_LOG_ITER  = 4'd3;
    localparam logic [3:0] ST_EXP_SETUP = 4'd4;
    localparam logic [3:0] ST_EXP_ITER  = 4'd5;
    localparam logic [3:0] ST_SCALE     = 4'd6;
    localparam logic [3:0] ST_EMA_A     = 4'd7;
    localparam logic [3:0] ST_EMA_B     = 4'd8;
    localparam logic [3:0] ST_OUT       = 4'd9;

    localparam logic [511:0] EXP_COEF = gsp_pkg::exp_coef_table();
    localparam int LB = gsp_pkg::LOG_BITS;
    localparam int EB = gsp_pkg::EP_BITS;

    logic [3:0]             state_reg, state_next;
    gsp_pkg::sample_t       avg_reg, avg_next;
    logic [1:0]             op_idx_reg, op_idx_next;
    logic [3:0]             iter_reg, iter_next;
    logic [31:0]            man_reg, man_next;
    logic [3:0]             lead_reg, lead_next;
    logic [15:0]            frac_reg, frac_next;
    logic signed [LB-1:0]   lg_reg, lg_next;
    logic signed [8:0]      exp_int_reg, exp_int_next;
    logic [15:0]            exp_frac_reg, exp_frac_next;
    logic [31:0]            raw_reg, raw_next;
    logic                   clip_reg, clip_next;
    logic [48:0]            prod_reg, prod_next;
    logic [31:0]            smooth_reg, smooth_next;
    logic                   first_reg, first_next;
    logic                   out_valid_reg, out_valid_next;
    logic [15:0]            out_ppm_reg, out_ppm_next;
    gsp_pkg::sample_t       out_avg_reg, out_avg_next;
    logic                   out_sat_reg, out_sat_next;

    logic [15:0]            load_eff, clean_eff, op_val;
    logic [3:0]             op_lead;
    logic [31:0]            op_man;
    logic [61:0]            sq_full;
    logic [31:0]            sq;
    logic [19:0]            log_val;
    logic [61:0]            emul_full;
    logic [31:0]            coef;
    logic signed [EB-1:0]   slope_prod;
    logic signed [EB-1:0]   ep;
    logic signed [9:0]      rshift;
    logic [16:0]            w_eff;
    logic [49:0]            ema_sum;

    assign load_eff  = (cfg.load_resistance == '0) ? 16'd1 : cfg.load_resistance;
    assign clean_eff = (cfg.clean_air_resistance == '0) ? 16'd1 : cfg.clean_air_resistance;
    assign w_eff     = (cfg.smoothing_weight > gsp_pkg::WEIGHT_ONE) ?
                       gsp_pkg::WEIGHT_ONE : cfg.smoothing_weight;

    // log operands in order: FS-avg, load, avg, clean (last two subtracted)
    always_comb begin
        case (op_idx_reg)
            2'd0:    op_val = 16'(gsp_pkg::FULL_SCALE - avg_reg);
            2'd1:    op_val = load_eff;
            2'd2:    op_val = 16'(avg_reg);
            default: op_val = clean_eff;
        endcase
        op_lead = '0;
        for (int i = 0; i < 16; i++) begin
            if (op_val[i]) op_lead = 4'(i);
        end
    end

    assign op_man    = 32'(op_val) << (5'd30 - {1'b0, op_lead});
    assign sq_full   = man_reg[30:0] * man_reg[30:0];
    assign sq        = sq_full[61:30];
    assign log_val   = {lead_reg, frac_reg[14:0], sq[31]};
    assign coef      = EXP_COEF[{iter_reg, 5'd0} +: 32];
    assign emul_full = man_reg[30:0] * coef[30:0];
    assign slope_prod = $signed({{(EB-18){1'b0}}, gsp_pkg::SLOPE_Q16}) *
                        $signed({{(EB-LB){lg_reg[LB-1]}}, lg_reg});
    assign ep        = $signed(gsp_pkg::LOG2_GAIN_Q32) - slope_prod;
    assign rshift    = 10'sd14 - $signed({exp_int_reg[8], exp_int_reg});
    assign ema_sum   = 50'(prod_reg) + 50'(smooth_reg) * 50'(gsp_pkg::WEIGHT_ONE - w_eff);

    assign blk_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        avg_next       = avg_reg;
        op_idx_next    = op_idx_reg;
        iter_next      = iter_reg;
        man_next       = man_reg;
        lead_next      = lead_reg;
        frac_next      = frac_reg;
        lg_next        = lg_reg;
        exp_int_next   = exp_int_reg;
        exp_frac_next  = exp_frac_reg;
        raw_next       = raw_reg;
        clip_next      = clip_reg;
        prod_next      = prod_reg;
        smooth_next    = smooth_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_ppm_next   = out_ppm_reg;
        out_avg_next   = out_avg_reg;
        out_sat_next   = out_sat_reg;

        case (state_reg)
            ST_IDLE: begin
                if (blk_valid) begin
                    avg_next   = blk_avg;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                op_idx_next = '0;
                lg_next     = '0;
                if (avg_reg == '0) begin
                    raw_next   = '0;
                    clip_next  = 1'b0;
                    state_next = ST_EMA_A;
                end else if (avg_reg == gsp_pkg::FULL_SCALE) begin
                    raw_next   = gsp_pkg::Q16_MAX;
                    clip_next  = 1'b1;
                    state_next = ST_EMA_A;
                end else begin
                    state_next = ST_LOG_INIT;
                end
            end
            ST_LOG_INIT: begin
                lead_next  = op_lead;
                man_next   = op_man;
                frac_next  = '0;
                iter_next  = '0;
                state_next = ST_LOG_ITER;
            end
            ST_LOG_ITER: begin
                // square, renormalize into [1,2), one fraction bit per cycle
                frac_next = {frac_reg[14:0], sq[31]};
                man_next  = sq[31] ? {1'b0, sq[31:1]} : sq;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 4'd15) begin
                    if (op_idx_reg[1]) begin
                        lg_next = lg_reg - $signed({3'b000, log_val});
                    end else begin
                        lg_next = lg_reg + $signed({3'b000, log_val});
                    end
                    op_idx_next = op_idx_reg + 1'b1;
                    state_next  = (op_idx_reg == 2'd3) ? ST_EXP_SETUP : ST_LOG_INIT;
                end
            end
            ST_EXP_SETUP: begin
                exp_int_next  = ep[EB-1:32];
                exp_frac_next = ep[31:16];
                man_next      = 32'd1 << 30;
                iter_next     = '0;
                state_next    = ST_EXP_ITER;
            end
            ST_EXP_ITER: begin
                if (exp_frac_reg[4'd15 - iter_reg]) begin
                    man_next = emul_full[61:30];
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 4'd15) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                clip_next = 1'b0;
                if (exp_int_reg >= 9'sd16) begin
                    raw_next  = gsp_pkg::Q16_MAX;
                    clip_next = 1'b1;
                end else if (exp_int_reg >= 9'sd14) begin
                    raw_next = exp_int_reg[0] ? (man_reg << 1) : man_reg;
                end else if (rshift >= 10'sd32) begin
                    raw_next = '0;
                end else begin
                    raw_next = man_reg >> rshift[4:0];
                end
                state_next = ST_EMA_A;
            end
            ST_EMA_A: begin
                if (first_reg) begin
                    smooth_next = raw_reg;
                    first_next  = 1'b0;
                    state_next  = ST_OUT;
                end else begin
                    prod_next  = raw_reg * w_eff;
                    state_next = ST_EMA_B;
                end
            end
            ST_EMA_B: begin
                smooth_next = ema_sum[47:16];
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_ppm_next   = smooth_reg[31:16];
                    out_avg_next   = avg_reg;
                    out_sat_next   = clip_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            smooth_reg    <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            smooth_reg    <= smooth_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_reg      <= avg_next;
        op_idx_reg   <= op_idx_next;
        iter_reg     <= iter_next;
        man_reg      <= man_next;
        lead_reg     <= lead_next;
        frac_reg     <= frac_next;
        lg_reg       <= lg_next;
        exp_int_reg  <= exp_int_next;
        exp_frac_reg <= exp_frac_next;
        raw_reg      <= raw_next;
        clip_reg     <= clip_next;
        prod_reg     <= prod_next;
        out_ppm_reg  <= out_ppm_next;
        out_avg_reg  <= out_avg_next;
        out_sat_reg  <= out_sat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_ppm   = out_ppm_reg;
    assign out_avg   = out_avg_reg;
    assign out_sat   = out_sat_reg;

`ifndef SYNTHESIS
    a_man_normalized: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOG_ITER || state_reg == ST_EXP_ITER) |-> !man_reg[31])
        else $error("mantissa left [1,2)");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (blk_valid && blk_ready) |=> (state_reg == ST_START))
        else $error("block taken outside idle");

    a_zero_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START && avg_reg == '0) |=> (raw_reg == '0 && !clip_reg))
        else $error("zero average not mapped to zero ppm");

    a_out_from_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result loaded outside output state");
`endif

endmodule
